// ----- rtl/lphm_pkg.sv -----
package lphm_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int KEY_W  = 32;
  localparam int HDL_W  = 16;
  localparam int ECNT_W = 17;
  localparam int QDEPTH = 2;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_VALUE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_GET,
    CMD_BAD
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CHECK
  } bstate_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  home;
    logic [KEY_W-1:0]   key;
    logic [HDL_W-1:0]   handler;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } head_t;

endpackage

// ----- rtl/lphm_front.sv -----
module lphm_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 q_full,
  output lphm_pkg::push_t      push
);
  import lphm_pkg::*;

  logic [KEY_W-1:0] key;
  logic [HDL_W-1:0] hdl;

  assign key       = in_tdata[KEY_W-1:0];
  assign hdl       = in_tdata[KEY_W+HDL_W-1:KEY_W];
  assign in_tready = !q_full;

  always_comb begin
    push.vld         = in_tvalid && !q_full;
    push.cmd.key     = key;
    push.cmd.handler = hdl;
    push.cmd.home    = key[SLOT_W-1:0];
    if (op_t'(in_tuser[0]) == OP_GET) begin
      push.cmd.kind = CMD_GET;
    end else if (hdl == '0) begin
      push.cmd.kind = CMD_BAD;
    end else begin
      push.cmd.kind = CMD_SET;
    end
  end

endmodule

// ----- rtl/lphm_queue.sv -----
module lphm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  lphm_pkg::push_t  push,
  output logic             q_full,
  output lphm_pkg::head_t  head,
  input  logic             pop
);
  import lphm_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t              ent_r [QDEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W:0]    fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign q_full   = (fill_r == (PTR_W+1)'(QDEPTH));
  assign head.vld = (fill_r != '0);
  assign head.cmd = ent_r[rptr_r];
  assign do_push  = push.vld && !q_full;
  assign do_pop   = pop && head.vld;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push.cmd;
    end
  end

endmodule

// ----- rtl/lphm_back.sv -----
module lphm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lphm_pkg::head_t      head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,
  output logic [2:0]           out_tuser
);
  import lphm_pkg::*;

  bstate_t            state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0]  prb_r, prb_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [HDL_W-1:0]   out_hdl_r, out_hdl_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic [KEY_W-1:0]   key_mem [SLOTS];
  logic [HDL_W-1:0]   hdl_mem [SLOTS];
  logic               vld_r [SLOTS];
  logic [KEY_W-1:0]   rd_key_r;
  logic [HDL_W-1:0]   rd_hdl_r;
  logic               rd_vld_r;

  logic               rd_en, wr_en, fin, out_free, hit;

  assign out_free = !out_valid_r || out_tready;
  assign hit      = !rd_vld_r || (rd_key_r == cmd_r.key);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    prb_nxt        = prb_r;
    cnt_nxt        = cnt_r;
    out_status_nxt = out_status_r;
    out_hdl_nxt    = out_hdl_r;
    out_cnt_nxt    = out_cnt_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    fin            = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (head.vld && (head.cmd.kind != CMD_BAD || out_free)) begin
          pop     = 1'b1;
          cmd_nxt = head.cmd;
          pos_nxt = head.cmd.home;
          prb_nxt = '0;
          if (head.cmd.kind == CMD_BAD) begin
            fin            = 1'b1;
            out_status_nxt = ST_BAD_VALUE;
            out_hdl_nxt    = '0;
            out_cnt_nxt    = cnt_r;
          end else begin
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        rd_en     = 1'b1;
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (hit) begin
          if (out_free) begin
            fin         = 1'b1;
            state_nxt   = B_IDLE;
            out_hdl_nxt = '0;
            if (cmd_r.kind == CMD_SET) begin
              wr_en = 1'b1;
              if (!rd_vld_r) begin
                cnt_nxt        = cnt_r + 1'b1;
                out_status_nxt = ST_INSERTED;
              end else begin
                out_status_nxt = ST_UPDATED;
              end
            end else if (!rd_vld_r) begin
              out_status_nxt = ST_NOT_FOUND;
            end else begin
              out_status_nxt = ST_FOUND;
              out_hdl_nxt    = rd_hdl_r;
            end
            out_cnt_nxt = cnt_nxt;
          end
        end else if (prb_r == SLOT_W'(SLOTS-1)) begin
          if (out_free) begin
            fin            = 1'b1;
            state_nxt      = B_IDLE;
            out_hdl_nxt    = '0;
            out_cnt_nxt    = cnt_r;
            out_status_nxt = (cmd_r.kind == CMD_SET) ? ST_FULL : ST_NOT_FOUND;
          end
        end else begin
          pos_nxt   = pos_r + 1'b1;
          prb_nxt   = prb_r + 1'b1;
          state_nxt = B_READ;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = fin ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    prb_r        <= prb_nxt;
    out_status_r <= out_status_nxt;
    out_hdl_r    <= out_hdl_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // slot occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld_r[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[pos_r] <= cmd_r.key;
      hdl_mem[pos_r] <= cmd_r.handler;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[pos_r];
      rd_hdl_r <= hdl_mem[pos_r];
      rd_vld_r <= vld_r[pos_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, (ECNT_W-CNT_W)'(0), out_cnt_r, out_hdl_r};

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("entry count above table size");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(wr_en) && $past(!rd_vld_r)
                                 && cnt_r == $past(cnt_r) + 1'b1))
    else $error("entry count moved without an insert");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE && head.vld))
    else $error("queue popped while busy");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> out_free)
    else $error("result overwrote a pending one");

endmodule

// ----- rtl/linear_probe_hash_map_unit.sv -----
// a request is popped from the queue in idle; each slot probed (1 to 64 per request) takes a
// read state and a check state, one key/handler memory read per probe; a refused set (handler
// zero) ends at the pop; the engine serves one request at a time, and a 2-entry queue lets
// requests be accepted while the engine or the output register is busy
// reset: synchronous, active low; clears queue, probe state, output valid, slot occupancy flags
// and entry count together, no clearing pass
module linear_probe_hash_map_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key[31:0], handler[47:32]
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // handler_out[15:0], entry_count_out[32:16], zero[39:33]
  output logic [2:0]  out_tuser   // status[2:0]
);
  import lphm_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  lphm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push)
  );

  lphm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  lphm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lphm_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] handler;
    logic [16:0] count;
  } map_result_t;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [15:0] hdl;
    bit          typed;
    map_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  logic [31:0] map_key [SLOTS];
  logic [15:0] map_hdl [SLOTS];
  int unsigned map_count;

  map_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  logic [31:0] key_pool[$];
  int          mismatch_count;
  bit          calm;
  bit          hold_go;
  int          hold_left;

  linear_probe_hash_map_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic map_result_t mk_result(status_t s, logic [15:0] h, logic [16:0] c);
    map_result_t r;
    r.status  = s;
    r.handler = h;
    r.count   = c;
    return r;
  endfunction

  // probes the shadow table exactly as the block does and applies the request
  function automatic map_result_t apply_map_op(op_t op, logic [31:0] key, logic [15:0] hdl);
    map_result_t r;
    int unsigned home;
    int unsigned pos;
    int          i;
    r.status  = (op == OP_SET) ? ST_FULL : ST_NOT_FOUND;
    r.handler = '0;
    home      = key % SLOTS;
    if (op == OP_SET && hdl == 16'd0) begin
      r.status = ST_BAD_VALUE;
    end else begin
      for (i = 0; i < SLOTS; i++) begin
        pos = (home + i) % SLOTS;
        if (op == OP_SET) begin
          if (map_hdl[pos] == 16'd0 || map_key[pos] == key) begin
            if (map_hdl[pos] == 16'd0) begin
              map_count++;
              r.status = ST_INSERTED;
            end else begin
              r.status = ST_UPDATED;
            end
            map_key[pos] = key;
            map_hdl[pos] = hdl;
            break;
          end
        end else begin
          if (map_hdl[pos] == 16'd0) break;
          if (map_key[pos] == key) begin
            r.status  = ST_FOUND;
            r.handler = map_hdl[pos];
            break;
          end
        end
      end
    end
    r.count = 17'(map_count);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_row(op_t op, logic [31:0] key, logic [15:0] hdl, bit typed,
                         map_result_t want);
    stim_row_t row;
    row.op    = op;
    row.key   = key;
    row.hdl   = hdl;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic issue_request(op_t op, logic [31:0] key, logic [15:0] hdl, bit typed,
                               map_result_t want);
    map_result_t r;
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hdl, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    r = apply_map_op(op, key, hdl);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_handler(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 16'd0;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [31:0] pick_key(int fresh_pct);
    if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) return $urandom;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // receiver: random backpressure, calm stretches and one long hold-off
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  always @(posedge clk) begin : result_check
    map_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unrequested result status %0d data %h", out_tuser,
                                  out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        if (out_tdata[15:0] !== want.handler)
          report_mismatch($sformatf("handler %h, want %h", out_tdata[15:0], want.handler));
        if (out_tdata[32:16] !== want.count)
          report_mismatch($sformatf("entry count %0d, want %0d", out_tdata[32:16],
                                    want.count));
        if (out_tdata[39:33] !== 7'd0)
          report_mismatch($sformatf("pad bits %b not zero", out_tdata[39:33]));
      end
    end
  end

  initial begin
    map_result_t none;
    logic [31:0] k;
    op_t         op;
    int          i;
    none = mk_result(ST_NOT_FOUND, 16'd0, 17'd0);
    mismatch_count = 0;
    calm      = 1'b0;
    hold_go   = 1'b0;
    map_count = 0;
    for (i = 0; i < SLOTS; i++) begin
      map_key[i] = '0;
      map_hdl[i] = '0;
    end
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_GET, 32'h0000_0000, 16'h0000, 1, mk_result(ST_NOT_FOUND, 16'h0000, 17'd0));
    add_row(OP_SET, 32'h0000_0000, 16'h0000, 1, mk_result(ST_BAD_VALUE, 16'h0000, 17'd0));
    add_row(OP_SET, 32'h7fff_ffff, 16'hffff, 1, mk_result(ST_INSERTED, 16'h0000, 17'd1));
    add_row(OP_SET, 32'h8000_0000, 16'h0001, 1, mk_result(ST_INSERTED, 16'h0000, 17'd2));
    add_row(OP_GET, 32'h7fff_ffff, 16'h0000, 1, mk_result(ST_FOUND, 16'hffff, 17'd2));
    add_row(OP_GET, 32'h8000_0000, 16'hffff, 1, mk_result(ST_FOUND, 16'h0001, 17'd2));
    add_row(OP_SET, 32'h8000_0000, 16'h8000, 1, mk_result(ST_UPDATED, 16'h0000, 17'd2));
    add_row(OP_SET, 32'h8000_0000, 16'h0000, 1, mk_result(ST_BAD_VALUE, 16'h0000, 17'd2));
    // wrap from the last slot into a cluster at slot zero
    add_row(OP_SET, 32'hffff_ffff, 16'h1234, 0, none);
    add_row(OP_GET, 32'hffff_ffff, 16'h0000, 0, none);
    add_row(OP_GET, 32'h0000_003f, 16'h0000, 0, none);
    add_row(OP_SET, 32'h0000_0040, 16'h0007, 0, none);
    add_row(OP_SET, 32'h0000_0040, 16'hfffe, 0, none);
    add_row(OP_GET, 32'h0000_0040, 16'h0000, 0, none);
    add_row(OP_GET, 32'h0000_0080, 16'habcd, 0, none);
    add_row(OP_GET, 32'h0000_0000, 16'h0000, 0, none);
    add_row(OP_SET, 32'h0000_007f, 16'h5555, 0, none);
    add_row(OP_GET, 32'h0000_007f, 16'h0000, 0, none);
    add_row(OP_SET, 32'h0000_0000, 16'haaaa, 0, none);
    add_row(OP_GET, 32'h0000_0000, 16'h0000, 0, none);

    foreach (directed_rows[j])
      issue_request(directed_rows[j].op, directed_rows[j].key, directed_rows[j].hdl,
                    directed_rows[j].typed, directed_rows[j].want);
    drain_results();

    // key pool with half the keys crowded onto a few home slots
    for (i = 0; i < 28; i++) begin
      k = $urandom;
      if (i % 2 == 1) k[5:0] = 6'($urandom_range(0, 5));
      key_pool.push_back(k);
    end
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7fff_ffff);
    key_pool.push_back(32'hffff_ffff);

    // partly loaded table; output held off early so the input stalls
    hold_go = 1'b1;
    for (i = 0; i < 250; i++) begin
      calm = (i >= 110 && i < 190);
      op   = op_t'($urandom_range(0, 1));
      issue_request(op, pick_key(15), rand_handler(8), 0, none);
    end
    calm = 1'b0;
    drain_results();

    // fill every remaining slot with fresh keys
    while (map_count < SLOTS) begin
      k = $urandom;
      key_pool.push_back(k);
      issue_request(OP_SET, k, rand_handler(0), 0, none);
    end
    drain_results();

    // full table: updates, refused inserts, zero-handler sets, hits and full-length misses
    for (i = 0; i < 250; i++) begin
      op = op_t'($urandom_range(0, 1));
      issue_request(op, pick_key(30), rand_handler(6), 0, none);
    end
    drain_results();

    repeat (140) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
